### src/slfr_pkg.sv
// Shared constants and types for the sync/length frame responder.
// No dependencies.
package slfr_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'h55;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;
  localparam logic [7:0] TRAILER_BYTE = 8'hCC;
  localparam logic [7:0] OP_CONNECT   = 8'h01;
  localparam logic [7:0] OP_SPECIAL   = 8'h03;
  localparam logic [8:0] FRAME_EXTRA  = 9'd4;

  localparam int         CNT_W        = 9;

  localparam logic [CNT_W-1:0] CNT_SYNC   = 9'd0;
  localparam logic [CNT_W-1:0] CNT_LENGTH = 9'd1;
  localparam logic [CNT_W-1:0] CNT_OPCODE = 9'd2;

  localparam logic [1:0] POS_SYNC    = 2'd0;
  localparam logic [1:0] POS_ZERO    = 2'd1;
  localparam logic [1:0] POS_OPCODE  = 2'd2;
  localparam logic [1:0] POS_TRAILER = 2'd3;

  typedef struct packed {
    logic fire;
    logic special;
  } reply_evt_t;

endpackage

### src/slfr_framer.sv
// Frame tracker: counts received bytes, captures length and opcode and raises a reply
// event when a frame completes (before connection, only for a connect frame). Depends on slfr_pkg.
module slfr_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output slfr_pkg::reply_evt_t evt
);
  import slfr_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       frame_length, frame_length_next;
  logic [7:0]       frame_opcode, frame_opcode_next;
  logic             connected_mode, connected_mode_next;
  logic [CNT_W-1:0] cnt_inc;
  logic             done;

  always_comb begin
    byte_count_next     = byte_count;
    frame_length_next   = frame_length;
    frame_opcode_next   = frame_opcode;
    connected_mode_next = connected_mode;
    evt                 = '0;
    cnt_inc             = byte_count + 9'd1;
    done                = 1'b0;
    if (take && !(byte_count == CNT_SYNC && rx_byte != SYNC_BYTE)) begin
      if (byte_count == CNT_LENGTH) frame_length_next = rx_byte;
      if (byte_count == CNT_OPCODE) frame_opcode_next = rx_byte;
      byte_count_next = cnt_inc;
      done = (cnt_inc > CNT_OPCODE) &&
             (cnt_inc >= ({1'b0, frame_length_next} + FRAME_EXTRA));
      if (done) begin
        byte_count_next = CNT_SYNC;
        if (!connected_mode) begin
          if (frame_opcode_next == OP_CONNECT) begin
            connected_mode_next = 1'b1;
            evt.fire            = 1'b1;
          end
        end else begin
          evt.fire    = 1'b1;
          evt.special = (frame_opcode_next == OP_SPECIAL);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      frame_length   <= '0;
      frame_opcode   <= '0;
      connected_mode <= 1'b0;
    end else begin
      byte_count     <= byte_count_next;
      frame_length   <= frame_length_next;
      frame_opcode   <= frame_opcode_next;
      connected_mode <= connected_mode_next;
    end
  end

endmodule

### src/sync_length_frame_responder.sv
// Sync/length frame responder: one rx byte per cycle in, four-byte replies out.
// A completed frame's reply is registered into the reply slot, or into the holding slot while it is busy.
// Throughput: one rx item per cycle unless stalled; one further reply may wait in a
// holding slot behind the one being sent, so input stalls only when both fill.
// Reset (rst, synchronous): frame count, length, opcode cleared; not connected; no reply pending.
module sync_length_frame_responder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       reply_last
);
  import slfr_pkg::*;

  reply_evt_t evt;
  logic       take;
  logic       rep_valid, rep_valid_next;
  logic       rep_special, rep_special_next;
  logic [1:0] rep_idx, rep_idx_next;
  logic       pend_valid, pend_valid_next;
  logic       pend_special, pend_special_next;
  logic       sent, rep_done, slot_free;

  assign in_ready = !pend_valid;
  assign take     = in_valid && in_ready;

  slfr_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .evt     (evt)
  );

  assign out_valid  = rep_valid;
  assign reply_last = (rep_idx == POS_TRAILER);

  always_comb begin
    case (rep_idx)
      POS_SYNC:    tx_byte = SYNC_BYTE;
      POS_ZERO:    tx_byte = ZERO_BYTE;
      POS_OPCODE:  tx_byte = rep_special ? OP_SPECIAL : OP_CONNECT;
      POS_TRAILER: tx_byte = TRAILER_BYTE;
      default:     tx_byte = ZERO_BYTE;
    endcase
  end

  always_comb begin
    sent              = out_valid && out_ready;
    rep_done          = sent && (rep_idx == POS_TRAILER);
    slot_free         = !rep_valid || rep_done;
    rep_valid_next    = rep_valid;
    rep_special_next  = rep_special;
    rep_idx_next      = rep_idx;
    pend_valid_next   = pend_valid;
    pend_special_next = pend_special;
    if (sent && !rep_done) rep_idx_next = rep_idx + 2'd1;
    if (slot_free) begin
      rep_idx_next = POS_SYNC;
      if (pend_valid) begin
        rep_valid_next    = 1'b1;
        rep_special_next  = pend_special;
        pend_valid_next   = evt.fire;
        pend_special_next = evt.special;
      end else begin
        rep_valid_next   = evt.fire;
        rep_special_next = evt.special;
      end
    end else if (evt.fire) begin
      pend_valid_next   = 1'b1;
      pend_special_next = evt.special;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid  <= 1'b0;
      rep_idx    <= POS_SYNC;
      pend_valid <= 1'b0;
    end else begin
      rep_valid  <= rep_valid_next;
      rep_idx    <= rep_idx_next;
      pend_valid <= pend_valid_next;
    end
    rep_special  <= rep_special_next;
    pend_special <= pend_special_next;
  end

endmodule

### dv/sync_length_frame_responder_tb.sv
`timescale 1ns / 100ps
// Testbench for sync_length_frame_responder: directed frames, then random framed traffic.
// Predicts each reply byte from the rx byte stream and checks it on the output channel.
// Depends on slfr_pkg and the responder RTL only.
module sync_length_frame_responder_tb;
  import slfr_pkg::*;

  localparam int RX_ITEMS    = 370;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLDOFF_LEN = 60;

  typedef struct {
    logic [7:0] tx;
    logic       last;
  } reply_byte_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    bit         reply;
    logic [7:0] op;
  } stim_row_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] tx_byte;
  logic       reply_last;

  reply_byte_t reply_bytes_due[$];
  stim_row_t   directed_rows[24];

  logic [CNT_W-1:0] frame_cnt = '0;
  logic [7:0]       frm_len   = '0;
  logic [7:0]       frm_op    = '0;
  bit               linked    = 1'b0;

  int errors       = 0;
  int fed          = 0;
  int replies      = 0;
  int bytes_seen   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int rcv_cycle    = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  bit big_done     = 1'b0;
  bit stim_done    = 1'b0;

  sync_length_frame_responder uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .reply_last (reply_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Frame tracker: advances the framing state for one accepted rx byte.
  task automatic frame_track(input logic [7:0] b, output bit consumed, output bit replied,
                             output logic [7:0] reply_op);
    consumed = 1'b1;
    replied  = 1'b0;
    reply_op = OP_CONNECT;
    if (frame_cnt == CNT_SYNC && b != SYNC_BYTE) begin
      consumed = 1'b0;
      return;
    end
    if (frame_cnt == CNT_LENGTH)
      frm_len = b;
    else if (frame_cnt == CNT_OPCODE)
      frm_op = b;
    frame_cnt = frame_cnt + 1'b1;
    if (frame_cnt > CNT_OPCODE && frame_cnt >= {1'b0, frm_len} + FRAME_EXTRA) begin
      frame_cnt = CNT_SYNC;
      if (!linked) begin
        if (frm_op == OP_CONNECT) begin
          linked  = 1'b1;
          replied = 1'b1;
        end
      end else begin
        replied  = 1'b1;
        reply_op = (frm_op == OP_SPECIAL) ? OP_SPECIAL : OP_CONNECT;
      end
    end
  endtask

  task automatic queue_reply(input logic [7:0] op);
    reply_bytes_due.push_back('{tx: SYNC_BYTE,    last: 1'b0});
    reply_bytes_due.push_back('{tx: ZERO_BYTE,    last: 1'b0});
    reply_bytes_due.push_back('{tx: op,           last: 1'b0});
    reply_bytes_due.push_back('{tx: TRAILER_BYTE, last: 1'b1});
    replies++;
  endtask

  // Offer one item in bursts with random gaps; return at the accepting edge.
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic feed(input logic [7:0] b, input bit typed, input bit t_reply,
                      input logic [7:0] t_op);
    bit         consumed;
    bit         replied;
    logic [7:0] op;
    offer_byte(b);
    frame_track(b, consumed, replied, op);
    if (typed) begin
      if (t_reply)
        queue_reply(t_op);
    end else if (replied) begin
      queue_reply(op);
    end
    if (consumed)
      fed++;
  endtask

  task automatic feed_frame(input logic [7:0] len, input logic [7:0] op, input int body);
    feed(SYNC_BYTE, 1'b0, 1'b0, ZERO_BYTE);
    feed(len, 1'b0, 1'b0, ZERO_BYTE);
    feed(op, 1'b0, 1'b0, ZERO_BYTE);
    repeat (body) feed(8'($urandom_range(0, 255)), 1'b0, 1'b0, ZERO_BYTE);
  endtask

  initial begin
    int         kind;
    logic [7:0] len;
    logic [7:0] op;
    directed_rows = '{
      '{8'h00, 1'b1, 1'b0, ZERO_BYTE},  '{8'hFF, 1'b1, 1'b0, ZERO_BYTE},
      '{8'h55, 1'b0, 1'b0, ZERO_BYTE},  '{8'h00, 1'b0, 1'b0, ZERO_BYTE},
      '{8'h03, 1'b0, 1'b0, ZERO_BYTE},  '{8'hCC, 1'b1, 1'b0, ZERO_BYTE},
      '{8'h55, 1'b0, 1'b0, ZERO_BYTE},  '{8'h00, 1'b0, 1'b0, ZERO_BYTE},
      '{8'h01, 1'b0, 1'b0, ZERO_BYTE},  '{8'hAA, 1'b1, 1'b1, OP_CONNECT},
      '{8'hAA, 1'b1, 1'b0, ZERO_BYTE},  '{8'h55, 1'b0, 1'b0, ZERO_BYTE},
      '{8'h01, 1'b0, 1'b0, ZERO_BYTE},  '{8'h03, 1'b0, 1'b0, ZERO_BYTE},
      '{8'hFF, 1'b0, 1'b0, ZERO_BYTE},  '{8'h00, 1'b1, 1'b1, OP_SPECIAL},
      '{8'h55, 1'b0, 1'b0, ZERO_BYTE},  '{8'h00, 1'b0, 1'b0, ZERO_BYTE},
      '{8'hFF, 1'b0, 1'b0, ZERO_BYTE},  '{8'h00, 1'b1, 1'b1, OP_CONNECT},
      '{8'h55, 1'b0, 1'b0, ZERO_BYTE},  '{8'h00, 1'b0, 1'b0, ZERO_BYTE},
      '{8'h00, 1'b0, 1'b0, ZERO_BYTE},  '{8'h55, 1'b1, 1'b1, OP_CONNECT}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      feed(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].reply,
           directed_rows[i].op);

    while (fed < RX_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 30))
                                           : 8'($urandom_range(0, 3));
        if (!big_done && fed > 60) begin
          len      = 8'hFF;
          big_done = 1'b1;
        end
        case ($urandom_range(0, 3))
          0:       op = OP_CONNECT;
          1:       op = OP_SPECIAL;
          2:       op = ZERO_BYTE;
          default: op = 8'($urandom_range(0, 255));
        endcase
        feed_frame(len, op, int'(len) + 1);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4)) feed(8'($urandom_range(0, 255)), 1'b0, 1'b0, ZERO_BYTE);
      end else begin
        // truncated frame: the next sync byte lands inside its body
        len = 8'($urandom_range(1, 5));
        feed_frame(len, 8'($urandom_range(0, 255)), $urandom_range(0, int'(len) - 1));
      end
    end
    in_valid <= 1'b0;

    while (reply_bytes_due.size() != 0) @(posedge clk);
    stim_done = 1'b1;
    repeat (8) @(posedge clk);

    $display("covered %0d rx items incl. a 255-byte frame, %0d replies, %0d reply bytes checked",
             fed, replies, bytes_seen);
    $display("directed: bad sync, frames before connect, opcodes 0/1/3/unknown; random framing");
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Output side: check each item, then pick the next ready value.
  always @(posedge clk) begin
    reply_byte_t exp_b;
    logic        nxt;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (reply_bytes_due.size() == 0) begin
          $error("unexpected output item: tx_byte %02h reply_last %0b", tx_byte, reply_last);
          errors++;
        end else begin
          exp_b = reply_bytes_due.pop_front();
          if (tx_byte !== exp_b.tx) begin
            $error("tx_byte: expected %02h, got %02h", exp_b.tx, tx_byte);
            errors++;
          end
          if (reply_last !== exp_b.last) begin
            $error("reply_last: expected %0b, got %0b", exp_b.last, reply_last);
            errors++;
          end
        end
      end
      rcv_cycle++;
      if (!holdoff_done && fed >= 30) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN;
      end
      case ((rcv_cycle / 128) % 4)
        0:       nxt = 1'b1;
        1:       nxt = 1'($urandom_range(0, 1));
        2:       nxt = ($urandom_range(0, 3) != 0);
        default: nxt = (rcv_cycle % 7 < 2);
      endcase
      if (holdoff_left > 0) begin
        holdoff_left--;
        nxt = 1'b0;
      end
      out_ready <= nxt;
    end
  end

  always @(posedge clk) begin
    if (!rst && !stim_done) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
